// File: rtl/hires_ntsc_artifact_color_defines.svh
// ----------------------------------------------------------------------------
// Hi-res artifact color decoder: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HIRES_NTSC_ARTIFACT_COLOR_DEFINES_SVH
`define HIRES_NTSC_ARTIFACT_COLOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define HNAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define HNAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hnac_pkg.sv
// ----------------------------------------------------------------------------
// Hi-res artifact color decoder: package
// Widths, stream positions, slot type and the bit stream helpers.
// ----------------------------------------------------------------------------
package hnac_pkg;

    localparam int COL_W    = 6;
    localparam int X_W      = 10;
    localparam int COLOR_W  = 4;
    localparam int BYTE_W   = 8;
    localparam int STREAM_W = 24;
    localparam int R_W      = 5;

    localparam logic [R_W-1:0] R_FIRST          = 5'd3;
    localparam logic [R_W-1:0] R_END_COLOR      = 5'd13;
    localparam logic [R_W-1:0] R_END_COLOR_LAST = 5'd20;
    localparam logic [R_W-1:0] R_END_MONO       = 5'd16;
    localparam logic [R_W-1:0] R_END_MONO_LAST  = 5'd17;

    localparam logic [X_W-1:0] X_PER_BYTE = 10'd14;
    localparam logic [X_W-1:0] X_LEAD     = 10'd3;

    localparam logic [COLOR_W-1:0] COLOR_BLACK = 4'd0;
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 4'd15;

    typedef enum logic
    {
        MODE_COLOR = 1'b0,
        MODE_MONO  = 1'b1
    } mode_t;

    typedef struct packed
    {
        logic                valid;
        mode_t               mode;
        logic                last_byte;
        logic [STREAM_W-1:0] stream;
        logic [X_W-1:0]      x_start;
        logic [R_W-1:0]      r_start;
        logic [R_W-1:0]      r_end;
    } slot_t;

    // Bit i of the result is stream position 14*col - 3 + i.
    function automatic logic [STREAM_W-1:0] build_stream(
        input logic [BYTE_W-1:0] data,
        input logic [2:0]        pend,
        input logic              prev
    );
        logic [STREAM_W-1:0] s;
        s      = '0;
        s[2:0] = pend;
        if (data[7])
        begin
            s[3] = prev;
            for (int i = 0; i < 6; i++)
            begin
                s[4 + 2*i] = data[i];
                s[5 + 2*i] = data[i];
            end
            s[16] = data[6];
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                s[3 + 2*i] = data[i];
                s[4 + 2*i] = data[i];
            end
            s[15] = data[6];
            s[16] = data[6];
        end
        return s;
    endfunction

    function automatic logic [COLOR_W-1:0] rotr4(
        input logic [COLOR_W-1:0] v,
        input logic [1:0]         n
    );
        logic [2*COLOR_W-1:0] d;
        d = {v, v} >> n;
        return d[COLOR_W-1:0];
    endfunction

endpackage

// File: rtl/hnac_byte_if.sv
// ----------------------------------------------------------------------------
// Hi-res artifact color decoder: screen byte channel
// Valid/ready channel carrying one screen byte per beat.
// ----------------------------------------------------------------------------
interface hnac_byte_if;
    import hnac_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] video_byte;

    modport source
    (
        output valid,
        output video_byte,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  video_byte,
        output ready
    );
endinterface

// File: rtl/hnac_pixel_if.sv
// ----------------------------------------------------------------------------
// Hi-res artifact color decoder: pixel channel
// Valid/ready channel carrying one pixel per beat.
// ----------------------------------------------------------------------------
interface hnac_pixel_if;
    import hnac_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic [X_W-1:0]     pixel_x;
    logic               last;
    logic               line_done;

    modport source
    (
        output valid,
        output pixel_color,
        output pixel_x,
        output last,
        output line_done,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  pixel_color,
        input  pixel_x,
        input  last,
        input  line_done,
        output ready
    );
endinterface

// File: rtl/hires_ntsc_artifact_color.sv
// ----------------------------------------------------------------------------
// Hi-res artifact color decoder: top level
// Path: byte beat -> slot register -> output register. Throughput: one pixel
//   per cycle while the sink is ready and bytes keep coming; a byte gives 11
//   (first), 14 (middle) or 21 (last) pixels in color, 14 or 15 in mono.
// Reset: column, carried bits and mode clear at once; no clearing pass.
// ----------------------------------------------------------------------------
module hires_ntsc_artifact_color #(
    parameter int BYTES_PER_LINE = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    hnac_byte_if.sink    bytes,
    hnac_pixel_if.source pixels
);
    import hnac_pkg::*;

    slot_t slot;
    logic  load;
    logic  done;

    hnac_loader #(
        .BYTES_PER_LINE(BYTES_PER_LINE)
    ) u_loader (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bytes     (bytes),
        .done      (done),
        .slot      (slot),
        .load      (load)
    );

    hnac_emitter u_emitter (
        .clk    (clk),
        .rst_n  (rst_n),
        .slot   (slot),
        .load   (load),
        .done   (done),
        .pixels (pixels)
    );

endmodule

// File: rtl/hnac_loader.sv
// ----------------------------------------------------------------------------
// Hi-res artifact color decoder: byte loader
// Tracks the column and carried bits, expands each byte into its bit stream
// and holds it in the slot register while its pixels go out.
// ----------------------------------------------------------------------------
`include "hires_ntsc_artifact_color_defines.svh"

module hnac_loader #(
    parameter int BYTES_PER_LINE = 40
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    hnac_byte_if.sink      bytes,
    input  logic           done,
    output hnac_pkg::slot_t slot,
    output logic           load
);
    import hnac_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(BYTES_PER_LINE - 1);

    mode_t               mode_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic                prev6_reg;
    logic [2:0]          pend_reg;
    slot_t               slot_reg;
    slot_t               slot_next;
    logic                first;
    logic                last_byte;
    logic [STREAM_W-1:0] stream_next;
    logic [X_W-1:0]      base;
    logic                from_lead;

    assign first       = (col_reg == '0);
    assign last_byte   = (col_reg >= LAST_COL);
    assign stream_next = build_stream(bytes.video_byte,
                                      first ? 3'b000 : pend_reg,
                                      first ? 1'b0 : prev6_reg);
    assign base        = X_W'(col_reg) * X_PER_BYTE;
    assign from_lead   = (mode_reg == MODE_MONO) || first;
    assign col_next    = last_byte ? '0 : col_reg + COL_W'(1);

    assign bytes.ready = !slot_reg.valid || done;
    assign load        = bytes.valid && bytes.ready;
    assign slot        = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (done)
        begin
            slot_next.valid = 1'b0;
        end
        if (load)
        begin
            slot_next.valid     = 1'b1;
            slot_next.mode      = mode_reg;
            slot_next.last_byte = last_byte;
            slot_next.stream    = stream_next;
            slot_next.x_start   = from_lead ? base : base - X_LEAD;
            slot_next.r_start   = from_lead ? R_FIRST : '0;
            case (mode_reg)
                MODE_MONO:  slot_next.r_end = last_byte ? R_END_MONO_LAST : R_END_MONO;
                MODE_COLOR: slot_next.r_end = last_byte ? R_END_COLOR_LAST : R_END_COLOR;
                default:    slot_next.r_end = R_END_COLOR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_COLOR;
            col_reg   <= '0;
            prev6_reg <= 1'b0;
            pend_reg  <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= mode_t'(cfg_wdata);
            end
            if (load)
            begin
                col_reg   <= col_next;
                prev6_reg <= bytes.video_byte[6];
                pend_reg  <= stream_next[16:14];
            end
            slot_reg <= slot_next;
        end
    end

    `HNAC_ASSERT_IMP(a_load_only_when_free, clk, rst_n,
        load && slot_reg.valid, done, "byte taken over an unfinished slot")
    `HNAC_ASSERT_IMP(a_col_in_line, clk, rst_n,
        1'b1, col_reg <= LAST_COL, "column beyond end of line")
    `HNAC_ASSERT_NXT(a_line_wraps, clk, rst_n,
        load && last_byte, col_reg == '0, "column did not wrap after last byte")

endmodule

// File: rtl/hnac_emitter.sv
// ----------------------------------------------------------------------------
// Hi-res artifact color decoder: pixel emitter
// Walks the slot's stream one position per beat, forms the color window
// and drives the pixel output register.
// ----------------------------------------------------------------------------
`include "hires_ntsc_artifact_color_defines.svh"

module hnac_emitter (
    input  logic            clk,
    input  logic            rst_n,
    input  hnac_pkg::slot_t slot,
    input  logic            load,
    output logic            done,
    hnac_pixel_if.source    pixels
);
    import hnac_pkg::*;

    logic [R_W-1:0]      k_reg;
    logic [R_W-1:0]      k_next;
    logic                out_valid_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic [X_W-1:0]      x_reg;
    logic                last_reg;
    logic                line_done_reg;
    logic                advance;
    logic [R_W-1:0]      r;
    logic [X_W-1:0]      x;
    logic                at_end;
    logic [STREAM_W-1:0] shifted;
    logic [COLOR_W-1:0]  win;
    logic [COLOR_W-1:0]  color;

    assign advance = !out_valid_reg || pixels.ready;
    assign r       = slot.r_start + k_reg;
    assign x       = slot.x_start + X_W'(k_reg);
    assign at_end  = (r == slot.r_end);
    assign done    = slot.valid && advance && at_end;
    assign shifted = slot.stream >> r;
    assign win     = {shifted[0], shifted[1], shifted[2], shifted[3]};

    always_comb
    begin
        case (slot.mode)
            MODE_MONO:  color = shifted[0] ? COLOR_WHITE : COLOR_BLACK;
            MODE_COLOR: color = rotr4(win, x[1:0]);
            default:    color = COLOR_BLACK;
        endcase
    end

    always_comb
    begin
        k_next = k_reg;
        if (load)
        begin
            k_next = '0;
        end
        else if (slot.valid && advance)
        begin
            k_next = k_reg + R_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (advance)
            begin
                out_valid_reg <= slot.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && slot.valid)
        begin
            color_reg     <= color;
            x_reg         <= x;
            last_reg      <= at_end;
            line_done_reg <= at_end && slot.last_byte;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_color = color_reg;
    assign pixels.pixel_x     = x_reg;
    assign pixels.last        = last_reg;
    assign pixels.line_done   = line_done_reg;

    `HNAC_ASSERT_IMP(a_cursor_in_range, clk, rst_n,
        slot.valid, r <= slot.r_end, "stream cursor past end of byte")
    `HNAC_ASSERT_IMP(a_line_done_is_last, clk, rst_n,
        out_valid_reg && line_done_reg, last_reg, "line end not on last pixel of byte")

endmodule

// File: dv/hires_ntsc_artifact_color_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hi-res artifact color decoder: testbench
// Feeds screen bytes with random gaps and stalls, switches the display mode
// between bursts, and checks every pixel beat against an in-bench decoder.
// ----------------------------------------------------------------------------
module hires_ntsc_artifact_color_tb;
    import hnac_pkg::*;

    localparam int LINE_BYTES   = 40;
    localparam int RANDOM_BYTES = 360;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed
    {
        logic [COLOR_W-1:0] color;
        logic [X_W-1:0]     x;
        logic               last;
        logic               line_done;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    hnac_byte_if  byte_ch ();
    hnac_pixel_if pix_ch ();

    hires_ntsc_artifact_color #(
        .BYTES_PER_LINE (LINE_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bytes     (byte_ch),
        .pixels    (pix_ch)
    );

    logic [BYTE_W-1:0] byte_queue[$];
    pixel_t            pixel_expect[$];

    mode_t        line_mode;
    int           line_col;
    logic         line_bit6;
    logic [2:0]   line_tail;

    int     fail_count;
    logic   byte_took;
    logic   pix_took;
    int     byte_gap;
    int     byte_calm;
    int     pix_stall;
    int     pix_calm;
    pixel_t pix_got;
    pixel_t pix_want;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [BYTE_W-1:0] random_byte();
        logic [1:0] sel;
        sel = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
            return {sel[1], {7{sel[0]}}};
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] v);
        logic [STREAM_W-1:0] s;
        logic [3:0]          w;
        logic [3:0]          c;
        int                  pos;
        int                  r_lo;
        int                  r_hi;
        int                  x;
        bit                  first;
        bit                  final_byte;
        pixel_t              p;
        first      = (line_col == 0);
        final_byte = (line_col + 1 >= LINE_BYTES);
        s   = '0;
        pos = 3;
        if (!first)
            s[2:0] = line_tail;
        if (v[7])
        begin
            s[pos] = first ? 1'b0 : line_bit6;
            pos++;
        end
        for (int i = 0; i < 6; i++)
        begin
            s[pos]     = v[i];
            s[pos + 1] = v[i];
            pos += 2;
        end
        s[pos] = v[6];
        if (!v[7])
            s[pos + 1] = v[6];
        if (line_mode == MODE_MONO)
        begin
            r_lo = 3;
            r_hi = final_byte ? 17 : 16;
        end
        else
        begin
            r_lo = first ? 3 : 0;
            r_hi = final_byte ? 20 : 13;
        end
        for (int r = r_lo; r <= r_hi; r++)
        begin
            x = 14 * line_col + r - 3;
            if (line_mode == MODE_MONO)
                c = s[r] ? COLOR_WHITE : COLOR_BLACK;
            else
            begin
                w = {s[r], s[r + 1], s[r + 2], s[r + 3]};
                for (int k = 0; k < 4; k++)
                    c[k] = w[(k + x) % 4];
            end
            p.color     = c;
            p.x         = X_W'(x);
            p.last      = (r == r_hi);
            p.line_done = (r == r_hi) && final_byte;
            pixel_expect.push_back(p);
        end
        line_tail = s[16:14];
        line_bit6 = v[6];
        line_col  = final_byte ? 0 : line_col + 1;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_took <= 1'b0;
            pix_took  <= 1'b0;
            line_mode = MODE_COLOR;
            line_col  = 0;
            line_bit6 = 1'b0;
            line_tail = 3'b000;
        end
        else
        begin
            if (cfg_we)
                line_mode = mode_t'(cfg_wdata);
            byte_took <= byte_ch.valid && byte_ch.ready;
            pix_took  <= pix_ch.valid && pix_ch.ready;
            if (byte_ch.valid && byte_ch.ready)
                decode_byte(byte_ch.video_byte);
            if (pix_ch.valid && pix_ch.ready)
            begin
                pix_got = '{pix_ch.pixel_color, pix_ch.pixel_x, pix_ch.last, pix_ch.line_done};
                if (pixel_expect.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected pixel: color=%0d x=%0d last=%0b line_done=%0b",
                                 pix_got.color, pix_got.x, pix_got.last, pix_got.line_done);
                end
                else
                begin
                    pix_want = pixel_expect.pop_front();
                    if (pix_got !== pix_want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("pixel mismatch: exp color=%0d x=%0d last=%0b done=%0b",
                                     pix_want.color, pix_want.x, pix_want.last,
                                     pix_want.line_done);
                            $display("                got color=%0d x=%0d last=%0b done=%0b",
                                     pix_got.color, pix_got.x, pix_got.last,
                                     pix_got.line_done);
                        end
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            byte_ch.valid <= 1'b0;
        else if (!byte_ch.valid || byte_took)
        begin
            if (byte_took)
                byte_gap = draw_wait(byte_calm);
            if (byte_gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                byte_gap--;
            end
            else if (byte_queue.size() > 0)
            begin
                byte_ch.valid      <= 1'b1;
                byte_ch.video_byte <= byte_queue.pop_front();
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pix_ch.ready <= 1'b0;
        else
        begin
            if (pix_took)
                pix_stall = draw_wait(pix_calm);
            if (pix_stall > 0)
            begin
                pix_ch.ready <= 1'b0;
                pix_stall--;
            end
            else
                pix_ch.ready <= 1'b1;
        end
    end

    task automatic wait_drained();
        @(posedge clk);
        while (byte_queue.size() != 0 || byte_ch.valid || pixel_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_mode(input mode_t m);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int burst;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.video_byte = '0;
        pix_ch.ready       = 1'b0;
        fail_count         = 0;
        byte_gap           = 0;
        byte_calm          = 0;
        pix_stall          = 0;
        pix_calm           = 0;
        sent               = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        set_mode(MODE_COLOR);
        byte_queue = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h40, 8'hC0, 8'h01, 8'h81,
                       8'h55, 8'hAA, 8'hD5, 8'h2A, 8'h3F, 8'hBF, 8'h7E, 8'hFE};
        set_mode(MODE_MONO);
        byte_queue = '{8'hFF, 8'h00, 8'hC0, 8'h40, 8'h80};
        set_mode(MODE_COLOR);
        byte_queue = '{8'h41, 8'hC1, 8'h33, 8'hCC};

        while (sent < RANDOM_BYTES)
        begin
            set_mode(mode_t'($urandom_range(0, 1)));
            burst = $urandom_range(1, 60);
            if (burst > RANDOM_BYTES - sent)
                burst = RANDOM_BYTES - sent;
            repeat (burst) byte_queue.push_back(random_byte());
            sent += burst;
        end

        wait_drained();
        repeat (30) @(negedge clk);
        if (fail_count == 0 && pixel_expect.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
